>>> src/hpa_pkg.sv
// Shared types and constants for the HSLA pixel adjust block.
// Standalone package; used by hsl_pixel_adjust_unit.
`default_nettype none

package hpa_pkg;

    // Adjustment selected by the mode register
    typedef enum logic [2:0] {
        MODE_LIGHTEN    = 3'd0,
        MODE_DARKEN     = 3'd1,
        MODE_SATURATE   = 3'd2,
        MODE_DESATURATE = 3'd3,
        MODE_GRAYSCALE  = 3'd4,
        MODE_HUE_ROTATE = 3'd5,
        MODE_TWO_TONE   = 3'd6
    } mode_t;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_MODE      = 2'd0,
        REG_AMOUNT    = 2'd1,
        REG_HUE_SHIFT = 2'd2
    } reg_index_t;

    localparam int HUE_W = 15;
    localparam int Q16_W = 17;
    localparam int SHIFT_W = 16;
    localparam int SUM_W = 18;

    localparam logic [Q16_W-1:0] UNIT_Q16 = 17'd65536;
    localparam logic [Q16_W-1:0] AMOUNT_RESET = 17'd6554;

    // Hue constants in 1/64 degree
    localparam logic signed [SUM_W-1:0] HUE_FULL = 18'sd23040;
    localparam logic signed [SUM_W-1:0] HUE_FULL_NEG = -18'sd23040;
    localparam logic signed [SUM_W-1:0] HUE_FULL_X2 = 18'sd46080;
    localparam logic [HUE_W-1:0] TWO_TONE_HIGH = 15'd18784;
    localparam logic [HUE_W-1:0] TWO_TONE_LOW = 15'd7264;
    localparam logic [HUE_W-1:0] HUE_ORANGE = 15'd704;
    localparam logic [HUE_W-1:0] HUE_BLUE = 15'd13824;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [Q16_W-1:0] sat;
        logic [Q16_W-1:0] lum;
        logic [Q16_W-1:0] alpha;
    } pixel_t;

endpackage

`default_nettype wire

>>> src/hsl_pixel_adjust_unit.sv
// HSLA pixel adjust: top level with configuration registers and a two-stage pipeline.
// Depends on hpa_pkg for mode codes, register indexes and constants.
`default_nettype none

// One HSLA pixel in, one adjusted pixel out. The block accepts a pixel every
// clock cycle unless in_stall is high; each pixel passes through the input
// register, then the result register after an add, clamp or compare. out_valid
// is the valid bit of the result register, which takes the input stage whenever
// the output is not held. A stall on the output holds the result register and,
// once the input register is also full, stalls the input. Configuration (mode,
// amount, hue_shift at byte addresses 0, 4, 8) should be written only while no
// pixel is in flight.
module hsl_pixel_adjust_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // configuration port
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [3:0]                 paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // input channel
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [hpa_pkg::HUE_W-1:0]  hue_in,
    input  wire logic [hpa_pkg::Q16_W-1:0]  sat_in,
    input  wire logic [hpa_pkg::Q16_W-1:0]  lum_in,
    input  wire logic [hpa_pkg::Q16_W-1:0]  alpha_in,
    // output channel
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [hpa_pkg::HUE_W-1:0]       hue_out,
    output logic [hpa_pkg::Q16_W-1:0]       sat_out,
    output logic [hpa_pkg::Q16_W-1:0]       lum_out,
    output logic [hpa_pkg::Q16_W-1:0]       alpha_out
);
    import hpa_pkg::*;

    logic [2:0]         mode_reg;
    logic [Q16_W-1:0]   amount_reg;
    logic [SHIFT_W-1:0] hue_shift_reg;
    reg_index_t         cfg_index;
    logic               cfg_write;

    logic               s1_valid_reg;
    pixel_t             s1_pix_reg;
    logic               out_valid_reg;
    pixel_t             out_pix_reg;
    pixel_t             out_pix_next;

    logic               out_hold;
    logic [SUM_W-1:0]   sat_add;
    logic [SUM_W-1:0]   lum_add;
    logic [Q16_W-1:0]   sat_sub;
    logic [Q16_W-1:0]   lum_sub;
    logic signed [SUM_W-1:0] hue_sum;
    logic signed [SUM_W-1:0] hue_rot;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_index = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_LIGHTEN;
            amount_reg    <= AMOUNT_RESET;
            hue_shift_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MODE:      mode_reg      <= pwdata[2:0];
                REG_AMOUNT:    amount_reg    <= pwdata[Q16_W-1:0];
                REG_HUE_SHIFT: hue_shift_reg <= pwdata[SHIFT_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_MODE:      prdata = {29'd0, mode_reg};
            REG_AMOUNT:    prdata = {15'd0, amount_reg};
            REG_HUE_SHIFT: prdata = {16'd0, hue_shift_reg};
            default:       prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign out_hold = out_valid_reg && out_stall;
    assign in_stall = s1_valid_reg && out_hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (!out_hold)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_pix_reg.hue   <= hue_in;
            s1_pix_reg.sat   <= sat_in;
            s1_pix_reg.lum   <= lum_in;
            s1_pix_reg.alpha <= alpha_in;
        end
        if (s1_valid_reg && !out_hold)
            out_pix_reg <= out_pix_next;
    end

    // ---------------- pixel datapath ----------------
    assign sat_add = {1'b0, s1_pix_reg.sat} + {1'b0, amount_reg};
    assign lum_add = {1'b0, s1_pix_reg.lum} + {1'b0, amount_reg};
    assign sat_sub = (s1_pix_reg.sat >= amount_reg) ? s1_pix_reg.sat - amount_reg : '0;
    assign lum_sub = (s1_pix_reg.lum >= amount_reg) ? s1_pix_reg.lum - amount_reg : '0;

    assign hue_sum = $signed({3'b000, s1_pix_reg.hue})
                   + $signed({{(SUM_W-SHIFT_W){hue_shift_reg[SHIFT_W-1]}}, hue_shift_reg});

    // Wrap into one turn; a sum of exactly minus one turn lands on zero
    always_comb
    begin
        if (hue_sum >= HUE_FULL_X2)
            hue_rot = hue_sum - HUE_FULL_X2;
        else if (hue_sum >= HUE_FULL)
            hue_rot = hue_sum - HUE_FULL;
        else if (hue_sum < HUE_FULL_NEG)
            hue_rot = hue_sum + HUE_FULL_X2;
        else if (hue_sum < 0)
            hue_rot = hue_sum + HUE_FULL;
        else
            hue_rot = hue_sum;
    end

    always_comb
    begin
        out_pix_next = s1_pix_reg;
        case (mode_reg)
            MODE_LIGHTEN:
                out_pix_next.lum = (lum_add > {1'b0, UNIT_Q16}) ? UNIT_Q16 : lum_add[Q16_W-1:0];
            MODE_DARKEN:
                out_pix_next.lum = (lum_sub > UNIT_Q16) ? UNIT_Q16 : lum_sub;
            MODE_SATURATE:
                out_pix_next.sat = (sat_add > {1'b0, UNIT_Q16}) ? UNIT_Q16 : sat_add[Q16_W-1:0];
            MODE_DESATURATE:
                out_pix_next.sat = (sat_sub > UNIT_Q16) ? UNIT_Q16 : sat_sub;
            MODE_GRAYSCALE:
                out_pix_next.sat = '0;
            MODE_HUE_ROTATE:
                out_pix_next.hue = hue_rot[HUE_W-1:0];
            MODE_TWO_TONE:
                out_pix_next.hue = (s1_pix_reg.hue >= TWO_TONE_HIGH ||
                                    s1_pix_reg.hue < TWO_TONE_LOW) ? HUE_ORANGE : HUE_BLUE;
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign hue_out   = out_pix_reg.hue;
    assign sat_out   = out_pix_reg.sat;
    assign lum_out   = out_pix_reg.lum;
    assign alpha_out = out_pix_reg.alpha;

    // ---------------- assertions ----------------
    // A filled input stage always moves into the result register unless it is held
    a_s1_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_hold) |=> out_valid_reg)
        else $error("input stage beat lost on its way to the result register");

    // Input stalls only when both stages are full and the output is held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with a free pipeline stage");

    // A result register that was held keeps its pixel
    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_hold |=> (out_valid_reg && $stable(out_pix_reg)))
        else $error("held result register changed");

endmodule

`default_nettype wire
